/* hdl/gillespie_sir_event_step_assert.svh */
// Assertion macros used by the block's top-level RTL file.
`ifndef GILLESPIE_SIR_EVENT_STEP_ASSERT_SVH
`define GILLESPIE_SIR_EVENT_STEP_ASSERT_SVH

// Checked on every rising clock edge outside reset.
`define GSIR_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked on every rising clock edge, reset included.
`define GSIR_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* hdl/gsir_pkg.sv */
`default_nettype none

package gsir_pkg;

  localparam int unsigned RATE_W      = 48;
  localparam int unsigned TIME_W      = 64;
  localparam int unsigned UNI_W       = 32;
  localparam int unsigned CNT_FIELD_W = 20;
  localparam int unsigned TAL_FIELD_W = 32;
  localparam int unsigned TERM_W      = 60;
  localparam int unsigned SUM_W       = 62;
  localparam int unsigned ACC_W       = 112;
  localparam int unsigned LOG_W       = 38;
  localparam int unsigned FRAC_W      = 32;
  localparam int unsigned QUO_W       = LOG_W + FRAC_W;

  localparam logic [UNI_W-1:0]  LN2_Q32  = 32'd2977044472;
  localparam logic [TERM_W-1:0] TERM_CAP = '1;

  localparam logic [RATE_W-1:0]      RST_BIRTH_RATE     = 48'd2147483648000;
  localparam logic [RATE_W-1:0]      RST_DEATH_RATE     = 48'd2147483648;
  localparam logic [RATE_W-1:0]      RST_INFECTION_RATE = 48'd25769804;
  localparam logic [RATE_W-1:0]      RST_RECOVERY_RATE  = 48'd429496730;
  localparam logic [CNT_FIELD_W-1:0] RST_INIT_S         = 20'd100;
  localparam logic [CNT_FIELD_W-1:0] RST_INIT_I         = 20'd750;
  localparam logic [CNT_FIELD_W-1:0] RST_INIT_R         = 20'd150;
  localparam logic [TIME_W-1:0]      RST_REPORT_IVL     = 64'd4294967296;

  typedef enum logic [2:0] {
    CFG_BIRTH_RATE     = 3'd0,
    CFG_DEATH_RATE     = 3'd1,
    CFG_INFECTION_RATE = 3'd2,
    CFG_RECOVERY_RATE  = 3'd3,
    CFG_INIT_S         = 3'd4,
    CFG_INIT_I         = 3'd5,
    CFG_INIT_R         = 3'd6,
    CFG_REPORT_IVL     = 3'd7
  } cfg_idx_e;

  typedef enum logic [2:0] {
    KIND_BIRTH   = 3'd0,
    KIND_DEATH_S = 3'd1,
    KIND_DEATH_I = 3'd2,
    KIND_DEATH_R = 3'd3,
    KIND_INFECT  = 3'd4,
    KIND_RECOVER = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    TERM_DEATH   = 3'd0,
    TERM_SI      = 3'd1,
    TERM_INFECT  = 3'd2,
    TERM_RECOVER = 3'd3,
    TERM_TARGET  = 3'd4,
    TERM_VICTIM  = 3'd5,
    TERM_LN      = 3'd6
  } term_e;

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_TERM   = 9'b000000010,
    ST_TOTAL  = 9'b000000100,
    ST_DECIDE = 9'b000001000,
    ST_NORM   = 9'b000010000,
    ST_SQUARE = 9'b000100000,
    ST_LFIN   = 9'b001000000,
    ST_DIV    = 9'b010000000,
    ST_FIN    = 9'b100000000
  } state_e;

endpackage

`default_nettype wire

/* hdl/gsir_if.sv */
`default_nettype none

interface gsir_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] uniform_time;
  logic [31:0] uniform_event;
  logic [31:0] uniform_victim;

  modport source (output valid, uniform_time, uniform_event, uniform_victim,
                  input ready);
  modport sink (input valid, uniform_time, uniform_event, uniform_victim,
                output ready);
endinterface

interface gsir_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_kind;
  logic [19:0] susceptible_now;
  logic [19:0] infected_now;
  logic [19:0] recovered_now;
  logic [19:0] population_now;
  logic [63:0] sim_time;
  logic        report_valid;
  logic [31:0] births_interval;
  logic [31:0] deaths_interval;
  logic [31:0] infections_interval;
  logic [31:0] recoveries_interval;

  modport source (output valid, event_kind, susceptible_now, infected_now,
                  recovered_now, population_now, sim_time, report_valid,
                  births_interval, deaths_interval, infections_interval,
                  recoveries_interval, input ready);
  modport sink (input valid, event_kind, susceptible_now, infected_now,
                recovered_now, population_now, sim_time, report_valid,
                births_interval, deaths_interval, infections_interval,
                recoveries_interval, output ready);
endinterface

`default_nettype wire

/* hdl/gsir_div.sv */
`default_nettype none

module gsir_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [gsir_pkg::LOG_W-1:0]  num_i,
  input  wire logic [gsir_pkg::SUM_W-1:0]  den_i,
  output logic                             done_o,
  output logic [gsir_pkg::TIME_W-1:0]      quo_o
);
  import gsir_pkg::*;

  localparam int unsigned CNT_W = $clog2(QUO_W + 1);

  logic              busy_q;
  logic              done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [QUO_W-1:0]  dvd_q;
  logic [QUO_W-1:0]  quo_q;
  logic [SUM_W-1:0]  den_q;
  logic [SUM_W-1:0]  rem_q;
  logic [SUM_W:0]    rem_sh;
  logic              fits;
  logic [SUM_W:0]    rem_d;

  // One quotient bit per cycle, restoring.
  always_comb begin
    rem_sh = {rem_q, dvd_q[QUO_W-1]};
    fits   = rem_sh >= {1'b0, den_q};
    rem_d  = fits ? rem_sh - {1'b0, den_q} : rem_sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(QUO_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= {num_i, {FRAC_W{1'b0}}};
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[QUO_W-2:0], 1'b0};
      rem_q <= rem_d[SUM_W-1:0];
      quo_q <= {quo_q[QUO_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quo_o  = (|quo_q[QUO_W-1:TIME_W]) ? {TIME_W{1'b1}} : quo_q[TIME_W-1:0];

endmodule

`default_nettype wire

/* hdl/gillespie_sir_event_step.sv */
// One Gillespie event of an SIR model with births and deaths per input beat.
// The input channel carries three non-zero uniform fractions; the output
// channel returns the event kind, the counts and clock before the event, and
// the interval tallies whenever the clock has reached the next report point.
// Rates, start counts and the report interval are set through the write
// port; the user must write them only while the block is idle, as the block
// itself does not enforce this. Writing a start count restarts the run.
// The block takes one beat at a time and is not ready while it works. A beat
// uses seven 48 by 64 bit products on one shared 32 by 32 bit multiplier, a
// sum of the weights, 32 squaring steps of the logarithm on the same
// multiplier, event choice, log set-up and the final load, and a 70-step
// restoring divider for the waiting time, which dominates.
// The result sits in an output register; the block is ready again in the
// cycle after the result is loaded, and the final load waits while the
// receiver stalls with an earlier result still pending.
// Reset loads the default rates, the start counts, a zero clock, a zero
// report point and clear tallies.
`default_nettype none

module gillespie_sir_event_step #(
  parameter int unsigned POP_BITS   = 20,
  parameter int unsigned TALLY_BITS = 32
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  gsir_in_if.sink                        in_i,
  gsir_out_if.source                     out_o,
  input  wire logic                      cfg_we_i,
  input  wire gsir_pkg::cfg_idx_e        cfg_index_i,
  input  wire logic [63:0]               cfg_data_i
);
  import gsir_pkg::*;

  localparam longint unsigned POP_MAX_L = (64'd1 << POP_BITS) - 64'd1;
  localparam logic [POP_BITS-1:0] RST_S = POP_BITS'((64'(RST_INIT_S) > POP_MAX_L)
                                          ? POP_MAX_L : 64'(RST_INIT_S));
  localparam logic [POP_BITS-1:0] RST_I = POP_BITS'((64'(RST_INIT_I) > POP_MAX_L)
                                          ? POP_MAX_L : 64'(RST_INIT_I));
  localparam logic [POP_BITS-1:0] RST_R = POP_BITS'((64'(RST_INIT_R) > POP_MAX_L)
                                          ? POP_MAX_L : 64'(RST_INIT_R));
  localparam longint unsigned RST_SUM = 64'(RST_S) + 64'(RST_I) + 64'(RST_R);
  localparam logic [POP_BITS-1:0] RST_N = POP_BITS'((RST_SUM > POP_MAX_L)
                                          ? POP_MAX_L : RST_SUM);

  logic [RATE_W-1:0]      b_q, d_q, beta_q, gamma_q;
  logic [CNT_FIELD_W-1:0] init_s_q, init_i_q, init_r_q;
  logic [TIME_W-1:0]      rep_ivl_q;

  logic [POP_BITS-1:0]    s_q, i_q, r_q, n_q;
  logic [TIME_W-1:0]      clk_time_q, next_rep_q;
  logic [TALLY_BITS-1:0]  tb_q, td_q, ti_q, tr_q;

  state_e                 state_q;
  term_e                  term_q;
  logic [2:0]             ps_q;
  logic                   pend_q;
  logic [4:0]             cnt_q;
  logic                   out_valid_q;

  logic [UNI_W-1:0]       ut_q, ue_q, uv_q;
  logic [ACC_W-1:0]       acc_q;
  logic [63:0]            prod_q;
  logic [1:0]             sh_q;
  logic [TERM_W-1:0]      wd_q, wi_q, wr_q;
  logic [63:0]            si_q;
  logic [SUM_W-1:0]       cum1_q, cum2_q, total_q, target_q;
  logic [POP_BITS-1:0]    v_q;
  kind_e                  kind_q;
  logic [31:0]            x_q, f_q;
  logic [5:0]             kf_q;
  logic [LOG_W-1:0]       l_q;
  logic [TIME_W-1:0]      dt_q;

  logic [2:0]             ev_kind_q;
  logic [19:0]            s_now_q, i_now_q, r_now_q, n_now_q;
  logic [63:0]            time_now_q;
  logic                   rep_q;
  logic [31:0]            births_q, deaths_q, infs_q, recs_q;

  // Restart values from the configuration as it will stand after this edge.
  logic [CNT_FIELD_W-1:0] init_s_n, init_i_n, init_r_n;
  logic [POP_BITS-1:0]    rs_s, rs_i, rs_r, rs_n;
  logic [POP_BITS+1:0]    rs_sum;
  logic                   restart;

  always_comb begin
    init_s_n = (cfg_we_i && cfg_index_i == CFG_INIT_S) ? cfg_data_i[19:0] : init_s_q;
    init_i_n = (cfg_we_i && cfg_index_i == CFG_INIT_I) ? cfg_data_i[19:0] : init_i_q;
    init_r_n = (cfg_we_i && cfg_index_i == CFG_INIT_R) ? cfg_data_i[19:0] : init_r_q;
    rs_s = POP_BITS'((64'(init_s_n) > POP_MAX_L) ? POP_MAX_L : 64'(init_s_n));
    rs_i = POP_BITS'((64'(init_i_n) > POP_MAX_L) ? POP_MAX_L : 64'(init_i_n));
    rs_r = POP_BITS'((64'(init_r_n) > POP_MAX_L) ? POP_MAX_L : 64'(init_r_n));
    rs_sum = (POP_BITS+2)'(rs_s) + (POP_BITS+2)'(rs_i) + (POP_BITS+2)'(rs_r);
    rs_n = (rs_sum > (POP_BITS+2)'(POP_MAX_L)) ? POP_BITS'(POP_MAX_L)
                                                : POP_BITS'(rs_sum);
    restart = cfg_we_i && (cfg_index_i == CFG_INIT_S || cfg_index_i == CFG_INIT_I ||
                           cfg_index_i == CFG_INIT_R);
  end

  // Shared multiplier and its operand selection.
  logic [RATE_W-1:0] op_a;
  logic [63:0]       op_b;
  logic [31:0]       mul_a, mul_b;
  logic [63:0]       mul_p;
  logic [1:0]        part_sh;

  always_comb begin
    case (term_q)
      TERM_DEATH:   begin op_a = d_q;                op_b = 64'(n_q);    end
      TERM_SI:      begin op_a = RATE_W'(s_q);       op_b = 64'(i_q);    end
      TERM_INFECT:  begin op_a = beta_q;             op_b = si_q;        end
      TERM_RECOVER: begin op_a = gamma_q;            op_b = 64'(i_q);    end
      TERM_TARGET:  begin op_a = RATE_W'(ue_q);      op_b = 64'(total_q); end
      TERM_VICTIM:  begin op_a = RATE_W'(uv_q);      op_b = 64'(n_q);    end
      TERM_LN:      begin op_a = RATE_W'(LN2_Q32);   op_b = 64'(l_q);    end
      default:      begin op_a = '0;                 op_b = '0;          end
    endcase
    if (state_q == ST_SQUARE) begin
      mul_a = x_q;
      mul_b = x_q;
    end else begin
      mul_a = ps_q[1] ? {16'b0, op_a[RATE_W-1:32]} : op_a[31:0];
      mul_b = ps_q[0] ? op_b[63:32] : op_b[31:0];
    end
    mul_p = mul_a * mul_b;
    case (ps_q[1:0])
      2'd0:    part_sh = 2'd0;
      2'd3:    part_sh = 2'd2;
      default: part_sh = 2'd1;
    endcase
  end

  logic [ACC_W-1:0]  part_ext;
  logic [TERM_W-1:0] term_sat;

  always_comb begin
    case (sh_q)
      2'd0:    part_ext = ACC_W'(prod_q);
      2'd1:    part_ext = ACC_W'(prod_q) << 32;
      default: part_ext = ACC_W'(prod_q) << 64;
    endcase
    term_sat = (|acc_q[ACC_W-1:TERM_W]) ? TERM_CAP : acc_q[TERM_W-1:0];
  end

  // Logarithm front end: leading one and normalisation.
  logic [31:0] u_eff, x_norm;
  logic [4:0]  k_top;

  always_comb begin
    u_eff = (ut_q == '0) ? 32'd1 : ut_q;
    k_top = '0;
    for (int j = 0; j < 32; j++) begin
      if (u_eff[j]) k_top = 5'(j);
    end
    x_norm = u_eff << (5'd31 - k_top);
  end

  // Divider for the waiting time.
  logic              div_start, div_done;
  logic [TIME_W-1:0] div_quo;

  assign div_start = (state_q == ST_TERM) && (term_q == TERM_LN) && (ps_q == 3'd5);

  gsir_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (acc_q[FRAC_W +: LOG_W]),
    .den_i   (total_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // Event choice.
  logic [POP_BITS:0] si_sum;
  kind_e             kind_d;

  always_comb begin
    si_sum = (POP_BITS+1)'(s_q) + (POP_BITS+1)'(i_q);
    if (total_q == '0 || target_q < SUM_W'(b_q)) begin
      kind_d = KIND_BIRTH;
    end else if (target_q < cum1_q) begin
      if (v_q < s_q) begin
        kind_d = KIND_DEATH_S;
      end else if ((POP_BITS+1)'(v_q) < si_sum) begin
        kind_d = KIND_DEATH_I;
      end else begin
        kind_d = KIND_DEATH_R;
      end
    end else if (target_q < cum2_q) begin
      kind_d = KIND_INFECT;
    end else begin
      kind_d = KIND_RECOVER;
    end
  end

  // Final update of the state.
  logic                  in_fire, fin_fire, report;
  logic [TALLY_BITS-1:0] tb_d, td_d, ti_d, tr_d;
  logic [POP_BITS-1:0]   s_d, i_d, r_d, n_d;
  logic [TIME_W:0]       clk_sum, rep_sum;

  assign in_fire  = in_i.valid && in_i.ready;
  assign fin_fire = (state_q == ST_FIN) && (!out_valid_q || out_o.ready);
  assign report   = clk_time_q >= next_rep_q;

  always_comb begin
    s_d  = s_q;
    i_d  = i_q;
    r_d  = r_q;
    n_d  = n_q;
    tb_d = tb_q;
    td_d = td_q;
    ti_d = ti_q;
    tr_d = tr_q;
    case (kind_q)
      KIND_BIRTH: begin
        s_d  = (&s_q) ? s_q : s_q + 1'b1;
        n_d  = (&n_q) ? n_q : n_q + 1'b1;
        tb_d = (&tb_q) ? tb_q : tb_q + 1'b1;
      end
      KIND_DEATH_S, KIND_DEATH_I, KIND_DEATH_R: begin
        if (kind_q == KIND_DEATH_S) begin
          s_d = (s_q == '0) ? s_q : s_q - 1'b1;
        end else if (kind_q == KIND_DEATH_I) begin
          i_d = (i_q == '0) ? i_q : i_q - 1'b1;
        end else begin
          r_d = (r_q == '0) ? r_q : r_q - 1'b1;
        end
        n_d  = (n_q == '0) ? n_q : n_q - 1'b1;
        td_d = (&td_q) ? td_q : td_q + 1'b1;
      end
      KIND_INFECT: begin
        s_d  = (s_q == '0) ? s_q : s_q - 1'b1;
        i_d  = (&i_q) ? i_q : i_q + 1'b1;
        ti_d = (&ti_q) ? ti_q : ti_q + 1'b1;
      end
      default: begin
        i_d  = (i_q == '0) ? i_q : i_q - 1'b1;
        r_d  = (&r_q) ? r_q : r_q + 1'b1;
        tr_d = (&tr_q) ? tr_q : tr_q + 1'b1;
      end
    endcase
    clk_sum = {1'b0, clk_time_q} + {1'b0, dt_q};
    rep_sum = {1'b0, next_rep_q} + {1'b0, rep_ivl_q};
  end

  // Configuration, model state and sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_q         <= RST_BIRTH_RATE;
      d_q         <= RST_DEATH_RATE;
      beta_q      <= RST_INFECTION_RATE;
      gamma_q     <= RST_RECOVERY_RATE;
      init_s_q    <= RST_INIT_S;
      init_i_q    <= RST_INIT_I;
      init_r_q    <= RST_INIT_R;
      rep_ivl_q   <= RST_REPORT_IVL;
      s_q         <= RST_S;
      i_q         <= RST_I;
      r_q         <= RST_R;
      n_q         <= RST_N;
      clk_time_q  <= '0;
      next_rep_q  <= '0;
      tb_q        <= '0;
      td_q        <= '0;
      ti_q        <= '0;
      tr_q        <= '0;
      state_q     <= ST_IDLE;
      term_q      <= TERM_DEATH;
      ps_q        <= '0;
      pend_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_BIRTH_RATE:     b_q       <= cfg_data_i[RATE_W-1:0];
          CFG_DEATH_RATE:     d_q       <= cfg_data_i[RATE_W-1:0];
          CFG_INFECTION_RATE: beta_q    <= cfg_data_i[RATE_W-1:0];
          CFG_RECOVERY_RATE:  gamma_q   <= cfg_data_i[RATE_W-1:0];
          CFG_INIT_S:         init_s_q  <= cfg_data_i[CNT_FIELD_W-1:0];
          CFG_INIT_I:         init_i_q  <= cfg_data_i[CNT_FIELD_W-1:0];
          CFG_INIT_R:         init_r_q  <= cfg_data_i[CNT_FIELD_W-1:0];
          CFG_REPORT_IVL:     rep_ivl_q <= cfg_data_i;
          default: ;
        endcase
      end

      if (restart) begin
        s_q        <= rs_s;
        i_q        <= rs_i;
        r_q        <= rs_r;
        n_q        <= rs_n;
        clk_time_q <= '0;
        next_rep_q <= '0;
        tb_q       <= '0;
        td_q       <= '0;
        ti_q       <= '0;
        tr_q       <= '0;
      end else if (fin_fire) begin
        s_q        <= s_d;
        i_q        <= i_d;
        r_q        <= r_d;
        n_q        <= n_d;
        clk_time_q <= clk_sum[TIME_W] ? {TIME_W{1'b1}} : clk_sum[TIME_W-1:0];
        if (report) begin
          next_rep_q <= rep_sum[TIME_W] ? {TIME_W{1'b1}} : rep_sum[TIME_W-1:0];
          tb_q       <= '0;
          td_q       <= '0;
          ti_q       <= '0;
          tr_q       <= '0;
        end else begin
          tb_q       <= tb_d;
          td_q       <= td_d;
          ti_q       <= ti_d;
          tr_q       <= tr_d;
        end
      end

      if (fin_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            state_q <= ST_TERM;
            term_q  <= TERM_DEATH;
            ps_q    <= '0;
            pend_q  <= 1'b0;
          end
        end
        ST_TERM: begin
          pend_q <= !ps_q[2];
          if (ps_q == 3'd5) begin
            ps_q   <= '0;
            pend_q <= 1'b0;
            case (term_q)
              TERM_DEATH:   term_q <= TERM_SI;
              TERM_SI:      term_q <= TERM_INFECT;
              TERM_INFECT:  term_q <= TERM_RECOVER;
              TERM_RECOVER: state_q <= ST_TOTAL;
              TERM_TARGET:  term_q <= TERM_VICTIM;
              TERM_VICTIM:  state_q <= ST_DECIDE;
              default:      state_q <= ST_DIV;
            endcase
          end else begin
            ps_q <= ps_q + 1'b1;
          end
        end
        ST_TOTAL: begin
          if (ps_q == 3'd2) begin
            ps_q    <= '0;
            term_q  <= TERM_TARGET;
            state_q <= ST_TERM;
          end else begin
            ps_q <= ps_q + 1'b1;
          end
        end
        ST_DECIDE: state_q <= ST_NORM;
        ST_NORM: begin
          cnt_q   <= '0;
          state_q <= ST_SQUARE;
        end
        ST_SQUARE: begin
          cnt_q <= cnt_q + 1'b1;
          if (&cnt_q) begin
            state_q <= ST_LFIN;
          end
        end
        ST_LFIN: begin
          term_q  <= TERM_LN;
          ps_q    <= '0;
          pend_q  <= 1'b0;
          state_q <= ST_TERM;
        end
        ST_DIV: begin
          if (div_done) begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (fin_fire) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Datapath and result registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ut_q <= in_i.uniform_time;
      ue_q <= in_i.uniform_event;
      uv_q <= in_i.uniform_victim;
    end

    if (state_q != ST_TERM || ps_q == 3'd5) begin
      acc_q <= '0;
    end else if (pend_q) begin
      acc_q <= acc_q + part_ext;
    end
    if (state_q == ST_TERM && !ps_q[2]) begin
      prod_q <= mul_p;
      sh_q   <= part_sh;
    end

    if (state_q == ST_TERM && ps_q == 3'd5) begin
      case (term_q)
        TERM_DEATH:   wd_q     <= term_sat;
        TERM_SI:      si_q     <= acc_q[63:0];
        TERM_INFECT:  wi_q     <= term_sat;
        TERM_RECOVER: wr_q     <= term_sat;
        TERM_TARGET:  target_q <= acc_q[FRAC_W +: SUM_W];
        TERM_VICTIM:  v_q      <= acc_q[FRAC_W +: POP_BITS];
        default: ;
      endcase
    end

    if (state_q == ST_TOTAL) begin
      case (ps_q)
        3'd0:    cum1_q  <= SUM_W'(b_q) + SUM_W'(wd_q);
        3'd1:    cum2_q  <= cum1_q + SUM_W'(wi_q);
        default: total_q <= cum2_q + SUM_W'(wr_q);
      endcase
    end

    if (state_q == ST_DECIDE) begin
      kind_q <= kind_d;
    end

    if (state_q == ST_NORM) begin
      x_q  <= x_norm;
      kf_q <= 6'd32 - 6'(k_top);
      f_q  <= '0;
    end else if (state_q == ST_SQUARE) begin
      x_q <= mul_p[63] ? mul_p[63:32] : mul_p[62:31];
      f_q <= {f_q[30:0], mul_p[63]};
    end

    if (state_q == ST_LFIN) begin
      l_q <= {kf_q, 32'b0} - LOG_W'(f_q);
    end

    if (state_q == ST_DIV && div_done) begin
      dt_q <= div_quo;
    end

    if (fin_fire) begin
      ev_kind_q  <= kind_q;
      s_now_q    <= 20'(s_q);
      i_now_q    <= 20'(i_q);
      r_now_q    <= 20'(r_q);
      n_now_q    <= 20'(n_q);
      time_now_q <= clk_time_q;
      rep_q      <= report;
      births_q   <= report ? 32'(tb_d) : '0;
      deaths_q   <= report ? 32'(td_d) : '0;
      infs_q     <= report ? 32'(ti_d) : '0;
      recs_q     <= report ? 32'(tr_d) : '0;
    end
  end

  assign in_i.ready                = (state_q == ST_IDLE);
  assign out_o.valid               = out_valid_q;
  assign out_o.event_kind          = ev_kind_q;
  assign out_o.susceptible_now     = s_now_q;
  assign out_o.infected_now        = i_now_q;
  assign out_o.recovered_now       = r_now_q;
  assign out_o.population_now      = n_now_q;
  assign out_o.sim_time            = time_now_q;
  assign out_o.report_valid        = rep_q;
  assign out_o.births_interval     = births_q;
  assign out_o.deaths_interval     = deaths_q;
  assign out_o.infections_interval = infs_q;
  assign out_o.recoveries_interval = recs_q;

`include "gillespie_sir_event_step_assert.svh"

  `GSIR_ASSERT(a_busy_after_accept, in_fire |=> !in_i.ready, "ready after accepting a beat")
  `GSIR_ASSERT(a_result_loaded, fin_fire |=> out_valid_q, "result not presented")
  `GSIR_ASSERT(a_div_in_step, div_done |-> state_q == ST_DIV, "divider finished out of step")
  `GSIR_ASSERT(a_quiet_tallies, out_valid_q && !rep_q |-> (births_q | deaths_q | infs_q | recs_q) == '0, "tallies without a report")
  `GSIR_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> !out_valid_q && state_q == ST_IDLE, "not idle in reset")

endmodule

`default_nettype wire

/* tb/sv/gsir_tb_checker.sv */
`timescale 1ns / 100ps

module gsir_tb_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  gsir_in_if         in_i,
  gsir_out_if        out_i,
  input  logic       cfg_we_i,
  input  gsir_pkg::cfg_idx_e cfg_index_i,
  input  logic [63:0] cfg_data_i,
  output int         fail_count_o,
  output int         pending_o,
  output int         events_seen_o,
  output int         reports_seen_o
);
  import gsir_pkg::*;

  localparam logic [63:0] POP_MAX   = 64'd1048575;
  localparam logic [63:0] TALLY_MAX = 64'hFFFF_FFFF;

  typedef struct packed {
    logic [2:0]  kind;
    logic [19:0] s;
    logic [19:0] i;
    logic [19:0] r;
    logic [19:0] n;
    logic [63:0] t;
    logic        rep;
    logic [31:0] births;
    logic [31:0] deaths;
    logic [31:0] infections;
    logic [31:0] recoveries;
  } sir_event_t;

  sir_event_t events_due[$];

  logic [63:0] b_rate, d_rate, beta_rate, g_rate, init_s, init_i, init_r, ivl;
  logic [63:0] sus, inf, rec, pop, clk_t, next_rep;
  logic [63:0] n_births, n_deaths, n_infections, n_recoveries;

  function automatic logic [63:0] sat_mul(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = a * b;
    return (p > 128'h0FFF_FFFF_FFFF_FFFF) ? 64'h0FFF_FFFF_FFFF_FFFF : p[63:0];
  endfunction

  function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = a + b;
    return s[64] ? '1 : s[63:0];
  endfunction

  function automatic logic [63:0] neg_log(logic [31:0] u);
    int k;
    logic [63:0] x, f, l;
    logic [127:0] m;
    k = 31;
    f = 0;
    while (k > 0 && u[k] == 1'b0) k--;
    x = ({32'd0, u} << (31 - k)) & 64'hFFFF_FFFF;
    for (int j = 0; j < 32; j++) begin
      x = (x * x) >> 31;
      f = f << 1;
      if (x >= 64'h1_0000_0000) begin
        f[0] = 1'b1;
        x = x >> 1;
      end
    end
    l = (64'(32 - k) << 32) - f;
    m = {96'd0, l[31:0]} * LN2_Q32;
    return l[63:32] * 64'(LN2_Q32) + m[95:32];
  endfunction

  function automatic logic [63:0] wait_time(logic [63:0] num, logic [63:0] den);
    logic [127:0] q;
    if (den == 0) return '1;
    q = {num, 32'd0} / den;
    return (q > 128'hFFFF_FFFF_FFFF_FFFF) ? '1 : q[63:0];
  endfunction

  task automatic restart_run();
    sus = (init_s > POP_MAX) ? POP_MAX : init_s;
    inf = (init_i > POP_MAX) ? POP_MAX : init_i;
    rec = (init_r > POP_MAX) ? POP_MAX : init_r;
    pop = (sus + inf + rec > POP_MAX) ? POP_MAX : sus + inf + rec;
    clk_t = 0;
    next_rep = 0;
    n_births = 0;
    n_deaths = 0;
    n_infections = 0;
    n_recoveries = 0;
  endtask

  task automatic fire_event(logic [31:0] ut, logic [31:0] ue, logic [31:0] uv);
    logic [63:0] wb, wd, wi, wr, total, target, v, dt;
    logic [127:0] tl;
    sir_event_t e;
    wb = b_rate;
    wd = sat_mul(d_rate, pop);
    wi = sat_mul(beta_rate, sus * inf);
    wr = sat_mul(g_rate, inf);
    total = wb + wd + wi + wr;
    if (ut == 0) ut = 1;
    tl = {96'd0, total[31:0]} * ue;
    target = 64'(ue) * total[63:32] + tl[95:32];
    e = '0;
    if (total == 0 || target < wb) e.kind = KIND_BIRTH;
    else if (target < wb + wd) begin
      v = (64'(uv) * pop) >> 32;
      if (v < sus) e.kind = KIND_DEATH_S;
      else if (v < sus + inf) e.kind = KIND_DEATH_I;
      else e.kind = KIND_DEATH_R;
    end else if (target < wb + wd + wi) e.kind = KIND_INFECT;
    else e.kind = KIND_RECOVER;
    dt = (total == 0) ? '1 : wait_time(neg_log(ut), total);
    e.s = sus[19:0];
    e.i = inf[19:0];
    e.r = rec[19:0];
    e.n = pop[19:0];
    e.t = clk_t;
    case (kind_e'(e.kind))
      KIND_BIRTH: begin
        if (sus < POP_MAX) sus++;
        if (pop < POP_MAX) pop++;
        if (n_births < TALLY_MAX) n_births++;
      end
      KIND_DEATH_S, KIND_DEATH_I, KIND_DEATH_R: begin
        if (e.kind == KIND_DEATH_S && sus != 0) sus--;
        if (e.kind == KIND_DEATH_I && inf != 0) inf--;
        if (e.kind == KIND_DEATH_R && rec != 0) rec--;
        if (pop != 0) pop--;
        if (n_deaths < TALLY_MAX) n_deaths++;
      end
      KIND_INFECT: begin
        if (sus != 0) sus--;
        if (inf < POP_MAX) inf++;
        if (n_infections < TALLY_MAX) n_infections++;
      end
      default: begin
        if (inf != 0) inf--;
        if (rec < POP_MAX) rec++;
        if (n_recoveries < TALLY_MAX) n_recoveries++;
      end
    endcase
    if (clk_t >= next_rep) begin
      e.rep = 1'b1;
      e.births = n_births[31:0];
      e.deaths = n_deaths[31:0];
      e.infections = n_infections[31:0];
      e.recoveries = n_recoveries[31:0];
      next_rep = sat_add(next_rep, ivl);
      n_births = 0;
      n_deaths = 0;
      n_infections = 0;
      n_recoveries = 0;
    end
    clk_t = sat_add(clk_t, dt);
    events_due.push_back(e);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    sir_event_t got, want;
    if (!rst_ni) begin
      b_rate = RST_BIRTH_RATE;
      d_rate = RST_DEATH_RATE;
      beta_rate = RST_INFECTION_RATE;
      g_rate = RST_RECOVERY_RATE;
      init_s = RST_INIT_S;
      init_i = RST_INIT_I;
      init_r = RST_INIT_R;
      ivl = RST_REPORT_IVL;
      restart_run();
      events_due.delete();
      fail_count_o = 0;
      events_seen_o = 0;
      reports_seen_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_BIRTH_RATE:     b_rate = cfg_data_i & 64'hFFFF_FFFF_FFFF;
          CFG_DEATH_RATE:     d_rate = cfg_data_i & 64'hFFFF_FFFF_FFFF;
          CFG_INFECTION_RATE: beta_rate = cfg_data_i & 64'hFFFF_FFFF_FFFF;
          CFG_RECOVERY_RATE:  g_rate = cfg_data_i & 64'hFFFF_FFFF_FFFF;
          CFG_INIT_S: begin init_s = cfg_data_i & 64'hFFFFF; restart_run(); end
          CFG_INIT_I: begin init_i = cfg_data_i & 64'hFFFFF; restart_run(); end
          CFG_INIT_R: begin init_r = cfg_data_i & 64'hFFFFF; restart_run(); end
          default:            ivl = cfg_data_i;
        endcase
      end
      if (out_i.valid && out_i.ready) begin
        got = '{out_i.event_kind, out_i.susceptible_now, out_i.infected_now,
                out_i.recovered_now, out_i.population_now, out_i.sim_time,
                out_i.report_valid, out_i.births_interval, out_i.deaths_interval,
                out_i.infections_interval, out_i.recoveries_interval};
        events_seen_o++;
        if (got.rep) reports_seen_o++;
        if (events_due.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10) $display("Unexpected result beat: %p", got);
        end else begin
          want = events_due.pop_front();
          if (got !== want) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("Mismatch:\n  expected %p\n  actual   %p", want, got);
          end
        end
      end
      if (in_i.valid && in_i.ready)
        fire_event(in_i.uniform_time, in_i.uniform_event, in_i.uniform_victim);
    end
    pending_o = events_due.size();
  end
endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps

module tb;
  import gsir_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b1;
  logic cfg_we_i = 1'b0;
  cfg_idx_e cfg_index_i = CFG_BIRTH_RATE;
  logic [63:0] cfg_data_i = '0;
  int fail_count, pending, events_seen, reports_seen;
  int send_idle_pct, stall_pct, hold_cycles, quiet_cycles;

  gsir_in_if  in_ch ();
  gsir_out_if out_ch ();

  always #5 clk_i = ~clk_i;

  gillespie_sir_event_step dut (
    .clk_i, .rst_ni, .in_i(in_ch), .out_o(out_ch), .cfg_we_i, .cfg_index_i, .cfg_data_i
  );

  gsir_tb_checker checker_u (
    .clk_i, .rst_ni, .in_i(in_ch), .out_i(out_ch), .cfg_we_i, .cfg_index_i,
    .cfg_data_i, .fail_count_o(fail_count), .pending_o(pending),
    .events_seen_o(events_seen), .reports_seen_o(reports_seen)
  );

  initial begin
    in_ch.valid = 1'b0;
    in_ch.uniform_time = 32'd1;
    in_ch.uniform_event = 32'd1;
    in_ch.uniform_victim = 32'd1;
    out_ch.ready = 1'b0;
  end

  // The receiver stalls at the current rate, or throughout a hold-off.
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_ni)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("Watchdog expired with %0d results outstanding.", pending);
      $display("gillespie_sir_event_step regression: fail");
      $finish;
    end
  end

  task automatic send_beat(logic [31:0] ut, logic [31:0] ue, logic [31:0] uv);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.uniform_time <= ut;
    in_ch.uniform_event <= ue;
    in_ch.uniform_victim <= uv;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [63:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_fraction();
    case ($urandom_range(5))
      0: return 32'd1 << $urandom_range(31);
      1: return 32'hFFFF_FFFF - $urandom_range(3);
      default: return ($urandom == 0) ? 32'd1 : $urandom;
    endcase
  endfunction

  function automatic logic [63:0] rand_rate();
    case ($urandom_range(4))
      0: return 64'd0;
      1: return 64'hFFFF_FFFF_FFFF;
      default: return {32'd0, $urandom} >> $urandom_range(4);
    endcase
  endfunction

  task automatic random_phase(int n, int idle_pct, int stl_pct);
    send_idle_pct = idle_pct;
    stall_pct = stl_pct;
    repeat (n) send_beat(rand_fraction(), rand_fraction(), rand_fraction());
  endtask

  initial begin
    send_idle_pct = 0;
    stall_pct = 0;
    hold_cycles = 0;
    quiet_cycles = 0;
    rst_ni <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed beats on the reset settings: fraction extremes.
    send_beat(32'd1, 32'd1, 32'd1);
    send_beat(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_beat(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_beat(32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0001);
    send_beat(32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFE);
    drain();

    // Zero total rate: always a birth and a saturated clock.
    write_reg(CFG_BIRTH_RATE, 64'd0);
    write_reg(CFG_DEATH_RATE, 64'd0);
    write_reg(CFG_INFECTION_RATE, 64'd0);
    write_reg(CFG_RECOVERY_RATE, 64'd0);
    write_reg(CFG_REPORT_IVL, 64'd1);
    send_beat(32'd7, 32'd9, 32'd3);
    send_beat(32'd7, 32'd9, 32'd3);
    drain();

    // Empty population and a saturated death rate; death must never be picked.
    write_reg(CFG_DEATH_RATE, 64'hFFFF_FFFF_FFFF);
    write_reg(CFG_INIT_S, 64'd0);
    write_reg(CFG_INIT_I, 64'd0);
    write_reg(CFG_INIT_R, 64'd0);
    send_beat(32'd1, 32'hFFFF_FFFF, 32'd1);
    drain();
    write_reg(CFG_BIRTH_RATE, 64'd0);
    write_reg(CFG_INIT_R, 64'd0);
    send_beat(32'd100, 32'd100, 32'd100);
    drain();

    // Full counts: saturated population and big weights.
    write_reg(CFG_BIRTH_RATE, 64'h1_0000_0000);
    write_reg(CFG_INFECTION_RATE, 64'hFFFF_FFFF_FFFF);
    write_reg(CFG_RECOVERY_RATE, 64'hFFFF_FFFF_FFFF);
    write_reg(CFG_REPORT_IVL, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(CFG_INIT_S, 64'hFFFFF);
    write_reg(CFG_INIT_I, 64'hFFFFF);
    write_reg(CFG_INIT_R, 64'hFFFFF);
    for (int k = 0; k < 8; k++)
      send_beat(32'hFFFF_FFFF >> k, (32'd1 << (4 * k)) | 32'd1, 32'h2000_0000 * k + 1);
    drain();

    // Back to moderate settings; random content over the idling and stalling phases.
    write_reg(CFG_BIRTH_RATE, 64'd2147483648000);
    write_reg(CFG_DEATH_RATE, 64'd2147483648);
    write_reg(CFG_INFECTION_RATE, 64'd25769804);
    write_reg(CFG_RECOVERY_RATE, 64'd429496730);
    write_reg(CFG_REPORT_IVL, 64'd4294967296);
    write_reg(CFG_INIT_S, 64'd100);
    write_reg(CFG_INIT_I, 64'd750);
    write_reg(CFG_INIT_R, 64'd150);
    random_phase(250, 0, 0);
    random_phase(200, 67, 0);
    random_phase(200, 0, 67);
    random_phase(200, 22, 22);

    // Long receiver hold-off while the sender keeps offering beats.
    hold_cycles = 600;
    random_phase(10, 0, 0);
    drain();

    // Random settings and intervals, with tiny populations near zero in the first three passes.
    for (int p = 0; p < 8; p++) begin
      write_reg(CFG_BIRTH_RATE, rand_rate());
      write_reg(CFG_DEATH_RATE, rand_rate());
      write_reg(CFG_INFECTION_RATE, rand_rate());
      write_reg(CFG_RECOVERY_RATE, rand_rate());
      write_reg(CFG_REPORT_IVL, (p == 0) ? 64'd0 : {$urandom_range(3), $urandom});
      write_reg(CFG_INIT_S, (p < 3) ? $urandom_range(3) : $urandom_range(20'hFFFFF));
      write_reg(CFG_INIT_I, (p < 3) ? $urandom_range(3) : $urandom_range(20'hFFFFF));
      write_reg(CFG_INIT_R, (p < 3) ? $urandom_range(3) : $urandom_range(20'hFFFFF));
      random_phase(55, (p % 2) ? 67 : 0, (p % 3 == 0) ? 67 : 0);
      drain();
    end

    drain();
    $display("Checked %0d events, %0d of them carrying interval reports.",
             events_seen, reports_seen);
    if (fail_count == 0)
      $display("gillespie_sir_event_step regression: pass");
    else
      $display("gillespie_sir_event_step regression: fail");
    $finish;
  end
endmodule
